// File: hdl/psps_pkg.sv
// types and constants for the periodic surface pixel shader
// no dependencies; imported by periodic_surface_pixel_shader_top, psps_checker and testbench

package psps_pkg;

  // configuration port geometry
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  // schwarz p field gain
  localparam int SchwarzGain = 74;

  // reciprocal of 127 for an exact floor divide of values below 2**24
  localparam int          DivShift = 31;
  localparam logic [24:0] DivRecip = 25'd16909321;

  // config register reset values
  localparam logic [7:0] MorphRst = 8'd0;
  localparam logic [5:0] SharpRst = 6'd23;
  localparam logic [7:0] GlowRst  = 8'd0;
  localparam logic [7:0] DriveRst = 8'd255;
  localparam logic [7:0] HueRst   = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMorph = 3'd0,
    CfgSharp = 3'd1,
    CfgGlow  = 3'd2,
    CfgDrive = 3'd3,
    CfgHue   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [7:0] sine_x;
    logic signed [7:0] sine_y;
    logic signed [7:0] sine_z;
    logic signed [7:0] cosine_x;
    logic signed [7:0] cosine_y;
    logic signed [7:0] cosine_z;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] luminance;
    logic [7:0] palette_index;
  } pixel_out_t;

endpackage

// File: hdl/periodic_surface_pixel_shader_top.sv
// periodic surface pixel shader, ten stage pipeline
// depends on psps_pkg for payload structs, register codes and constants

// depth: ten register stages between the accepted input word and out_valid_o
// throughput: one word per cycle while out_ready_i holds; every stage is one register, bubbles collapse under stall
// the critical stage holds one 24 x 25 bit multiply (reciprocal divide by 127)
// reset: asynchronous active low; clears all valid bits and loads the register defaults
// datapath registers carry no reset
module periodic_surface_pixel_shader_top
  import psps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pixel_in_t           in_data_i,
  // shaded output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pixel_out_t          out_data_o,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int NumStages = 10;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] morph_q;
  logic [5:0] sharp_q;
  logic [7:0] glow_q;
  logic [7:0] drive_q;
  logic [7:0] hue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      morph_q <= MorphRst;
      sharp_q <= SharpRst;
      glow_q  <= GlowRst;
      drive_q <= DriveRst;
      hue_q   <= HueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMorph: morph_q <= cfg_data_i;
        CfgSharp: sharp_q <= cfg_data_i[5:0];
        CfgGlow:  glow_q  <= cfg_data_i;
        CfgDrive: drive_q <= cfg_data_i;
        CfgHue:   hue_q   <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // blend weights: first field gets 127 - m[6:0], second gets m[6:0]
  // below 128 the pair is gyroid / schwarz, from 128 up it is schwarz / diamond
  logic [6:0] wgt_a;
  logic [6:0] wgt_b;
  assign wgt_a = 7'd127 - morph_q[6:0];
  assign wgt_b = morph_q[6:0];

  // ---------------------------------------------------------------------------
  // pipeline control: per-stage valid bits, a stage loads when it is empty
  // or the stage after it moves
  // ---------------------------------------------------------------------------
  logic [NumStages:1] vld_q;
  logic [NumStages:1] stage_en;

  always_comb begin
    stage_en[NumStages] = !vld_q[NumStages] || out_ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stage_en[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (stage_en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = stage_en[1];
  assign out_valid_o = vld_q[NumStages];

  // ---------------------------------------------------------------------------
  // stage 1: pairwise products of sine and cosine terms
  // ---------------------------------------------------------------------------
  logic signed [15:0] s1_g0_q;   // sx * cy
  logic signed [15:0] s1_g1_q;   // sy * cz, shared by gyroid and diamond
  logic signed [15:0] s1_g2_q;   // sz * cx
  logic signed [15:0] s1_pss_q;  // sy * sz
  logic signed [15:0] s1_pcc_q;  // cy * cz
  logic signed [15:0] s1_pcs_q;  // cy * sz
  logic signed [9:0]  s1_csum_q; // cx + cy + cz
  logic signed [7:0]  s1_sx_q;
  logic signed [7:0]  s1_cx_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s1_g0_q   <= in_data_i.sine_x * in_data_i.cosine_y;
      s1_g1_q   <= in_data_i.sine_y * in_data_i.cosine_z;
      s1_g2_q   <= in_data_i.sine_z * in_data_i.cosine_x;
      s1_pss_q  <= in_data_i.sine_y * in_data_i.sine_z;
      s1_pcc_q  <= in_data_i.cosine_y * in_data_i.cosine_z;
      s1_pcs_q  <= in_data_i.cosine_y * in_data_i.sine_z;
      s1_csum_q <= 10'(in_data_i.cosine_x) + 10'(in_data_i.cosine_y)
                 + 10'(in_data_i.cosine_z);
      s1_sx_q   <= in_data_i.sine_x;
      s1_cx_q   <= in_data_i.cosine_x;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: gyroid sum, schwarz field, diamond partial sums
  // diamond = sx * (sy*sz + cy*cz) + cx * (sy*cz + cy*sz)
  // ---------------------------------------------------------------------------
  logic signed [16:0] s2_gyro_q;
  logic signed [15:0] s2_schw_q;
  logic signed [16:0] s2_da_q;
  logic signed [16:0] s2_db_q;
  logic signed [7:0]  s2_sx_q;
  logic signed [7:0]  s2_cx_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      s2_gyro_q <= 17'(s1_g0_q) + 17'(s1_g1_q) + 17'(s1_g2_q);
      s2_schw_q <= 16'(s1_csum_q * SchwarzGain);
      s2_da_q   <= 17'(s1_pss_q) + 17'(s1_pcc_q);
      s2_db_q   <= 17'(s1_g1_q) + 17'(s1_pcs_q);
      s2_sx_q   <= s1_sx_q;
      s2_cx_q   <= s1_cx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: full diamond numerator
  // ---------------------------------------------------------------------------
  logic signed [24:0] s3_dnum_q;
  logic signed [16:0] s3_gyro_q;
  logic signed [15:0] s3_schw_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      s3_dnum_q <= 25'(s2_sx_q) * 25'(s2_da_q) + 25'(s2_cx_q) * 25'(s2_db_q);
      s3_gyro_q <= s2_gyro_q;
      s3_schw_q <= s2_schw_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: diamond / 128 toward zero, pick the two fields to blend
  // ---------------------------------------------------------------------------
  logic signed [17:0] s4_diam;
  logic signed [17:0] s4_opa_q;
  logic signed [17:0] s4_opb_q;

  always_comb begin
    if (s3_dnum_q[24]) begin
      s4_diam = 18'((s3_dnum_q + 25'sd127) >>> 7);
    end else begin
      s4_diam = 18'(s3_dnum_q >>> 7);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      if (morph_q[7]) begin
        s4_opa_q <= 18'(s3_schw_q);
        s4_opb_q <= s4_diam;
      end else begin
        s4_opa_q <= 18'(s3_gyro_q);
        s4_opb_q <= 18'(s3_schw_q);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: weighted fields
  // ---------------------------------------------------------------------------
  logic signed [24:0] s5_pa_q;
  logic signed [24:0] s5_pb_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      s5_pa_q <= 25'(s4_opa_q) * 25'($signed({1'b0, wgt_a}));
      s5_pb_q <= 25'(s4_opb_q) * 25'($signed({1'b0, wgt_b}));
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: blend sum and magnitude; |x / 127| toward zero equals |x| / 127 floored
  // ---------------------------------------------------------------------------
  logic signed [25:0] s6_sum;
  logic [23:0]        s6_mag_q;

  assign s6_sum = 26'(s5_pa_q) + 26'(s5_pb_q);

  always_ff @(posedge clk_i) begin
    if (stage_en[6]) begin
      s6_mag_q <= s6_sum[25] ? 24'(-s6_sum) : 24'(s6_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: divide by 127 through the reciprocal, keep psi >> 6
  // ---------------------------------------------------------------------------
  logic [48:0] s7_prod;
  logic [11:0] s7_dist_q;

  assign s7_prod = 49'(s6_mag_q) * 49'(DivRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[7]) begin
      s7_dist_q <= s7_prod[48:DivShift+6];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: sharpness scale, surface and fill levels
  // ---------------------------------------------------------------------------
  logic [17:0] s8_prod;
  logic [9:0]  s8_d;
  logic [7:0]  s8_surf_q;
  logic [7:0]  s8_fill_q;

  assign s8_prod = 18'(s7_dist_q) * 18'(sharp_q);
  assign s8_d    = s8_prod[17:8];

  always_ff @(posedge clk_i) begin
    if (stage_en[8]) begin
      if (s8_d[9:8] != 2'b00) begin
        s8_surf_q <= 8'd0;
        s8_fill_q <= 8'd255;
      end else begin
        s8_surf_q <= ~s8_d[7:0];
        s8_fill_q <= s8_d[7:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: glow mix
  // ---------------------------------------------------------------------------
  logic [16:0] s9_sum;
  logic [7:0]  s9_mix_q;

  assign s9_sum = 17'(16'(s8_surf_q) * 16'(8'd255 - glow_q))
                + 17'(16'(s8_fill_q) * 16'(glow_q));

  always_ff @(posedge clk_i) begin
    if (stage_en[9]) begin
      s9_mix_q <= s9_sum[15:8];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: drive scale and palette index, output word register
  // ---------------------------------------------------------------------------
  logic [16:0] s10_prod;
  logic [7:0]  s10_lum;
  pixel_out_t  out_q;

  assign s10_prod = 17'(s9_mix_q) * 17'({1'b0, drive_q} + 9'd1);
  assign s10_lum  = s10_prod[15:8];

  always_ff @(posedge clk_i) begin
    if (stage_en[10]) begin
      out_q.luminance     <= s10_lum;
      out_q.palette_index <= {1'b0, s10_lum[7:1]} + hue_q;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

  // input only stalls when every stage holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted word lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[1])
    else $error("accepted word lost at pipeline entry");

  // surface and fill levels are complementary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> ((9'(s8_surf_q) + 9'(s8_fill_q)) == 9'd255))
    else $error("surface and fill levels out of step");
`endif

endmodule

// File: tb/psps_checker.sv
// scoreboard for the periodic surface pixel shader: watches the pixel, shade and register ports
// depends on psps_pkg for the payload structs, register codes and reset values

module psps_checker
  import psps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  pixel_in_t           in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  pixel_out_t          out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint BlendDiv   = 127;
  localparam longint DiamondDiv = 128;
  localparam longint MorphSplit = 128;

  // shadow copy of the shader registers
  logic [7:0] morph_q;
  logic [5:0] sharp_q;
  logic [7:0] glow_q;
  logic [7:0] drive_q;
  logic [7:0] hue_q;

  pixel_out_t pending_shades[$];

  function automatic pixel_out_t shade_pixel(pixel_in_t px);
    longint sx, sy, sz, cx, cy, cz;
    longint m, sharp, glow, drive, hue;
    longint gyroid, schwarz, diamond, psi, mag, dist_lvl;
    longint surface, fill, mix, lum;
    pixel_out_t shade;
    sx = px.sine_x;
    sy = px.sine_y;
    sz = px.sine_z;
    cx = px.cosine_x;
    cy = px.cosine_y;
    cz = px.cosine_z;
    m     = morph_q;
    sharp = sharp_q;
    glow  = glow_q;
    drive = drive_q;
    hue   = hue_q;

    gyroid  = sx * cy + sy * cz + sz * cx;
    schwarz = (cx + cy + cz) * SchwarzGain;
    diamond = (sx * sy * sz + sx * cy * cz + cx * sy * cz + cx * cy * sz) / DiamondDiv;

    // gyroid to schwarz p on the low half, schwarz p to diamond on the high half
    if (m < MorphSplit) begin
      psi = (gyroid * (BlendDiv - m) + schwarz * m) / BlendDiv;
    end else begin
      psi = (schwarz * (255 - m) + diamond * (m - MorphSplit)) / BlendDiv;
    end

    mag      = (psi < 0) ? -psi : psi;
    dist_lvl = ((mag >> 6) * sharp) >> 8;
    surface  = (dist_lvl > 255) ? 0 : 255 - dist_lvl;
    fill     = (dist_lvl > 255) ? 255 : dist_lvl;
    mix = (surface * (255 - glow) + fill * glow) >> 8;
    lum = ((mix & 255) * (drive + 1)) >> 8;

    shade.luminance     = 8'(lum);
    shade.palette_index = 8'((lum >> 1) + hue);
    return shade;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int errors_now;
    int accepted_in;
    int accepted_out;
    pixel_out_t want;
    errors_now   = 0;
    accepted_in  = 0;
    accepted_out = 0;
    if (!rst_ni) begin
      pending_shades.delete();
      morph_q       <= MorphRst;
      sharp_q       <= SharpRst;
      glow_q        <= GlowRst;
      drive_q       <= DriveRst;
      hue_q         <= HueRst;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // prediction uses the registers as they stand before this edge
      if (in_valid_i && in_ready_i) begin
        pending_shades.push_back(shade_pixel(in_data_i));
        accepted_in = 1;
      end

      if (out_valid_i && out_ready_i) begin
        accepted_out = 1;
        if (pending_shades.size() == 0) begin
          $error("shaded word with no pixel outstanding: luminance %0d palette_index %0d",
                 out_data_i.luminance, out_data_i.palette_index);
          errors_now++;
        end else begin
          want = pending_shades.pop_front();
          if (out_data_i.luminance !== want.luminance) begin
            $error("luminance mismatch: expected %0d, got %0d",
                   want.luminance, out_data_i.luminance);
            errors_now++;
          end
          if (out_data_i.palette_index !== want.palette_index) begin
            $error("palette_index mismatch: expected %0d, got %0d",
                   want.palette_index, out_data_i.palette_index);
            errors_now++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMorph: morph_q <= cfg_data_i;
          CfgSharp: sharp_q <= cfg_data_i[5:0];
          CfgGlow:  glow_q  <= cfg_data_i;
          CfgDrive: drive_q <= cfg_data_i;
          CfgHue:   hue_q   <= cfg_data_i;
          default: ;
        endcase
      end

      fail_count_o  <= fail_count_o + errors_now;
      outstanding_o <= outstanding_o + accepted_in - accepted_out;
    end
  end

endmodule

// File: tb/testbench.sv
// top of the periodic surface pixel shader testbench: clock, reset, pixel and register stimulus
// depends on psps_pkg, periodic_surface_pixel_shader_top and psps_checker

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import psps_pkg::*;

  // cycles with no word moving on any port before the run is called hung
  localparam int WatchdogLimit = 2000;
  // pipeline depth from the head of the top level, plus margin for the drain at the end
  localparam int DrainCycles   = 30;
  localparam int HoldOffCycles = 80;
  localparam int NumPhases     = 10;
  localparam int PhaseItems    = 175;

  typedef struct packed {
    logic [7:0] morph;
    logic [5:0] sharp;
    logic [7:0] glow;
    logic [7:0] drive;
    logic [7:0] hue;
  } shade_setting_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  pixel_in_t           in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  pixel_out_t          out_data;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;

  int fail_count;
  int outstanding;
  int pixels_sent  = 0;
  int words_seen   = 0;
  int settings_run = 0;
  int idle_cycles  = 0;

  // handshake between the stimulus process and the output stall process
  int hold_off_asks  = 0;
  int hold_offs_done = 0;

  periodic_surface_pixel_shader_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  psps_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly back to back, some short gaps, now and then a long one
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic pixel_in_t make_pixel(int sx, int sy, int sz, int cx, int cy, int cz);
    pixel_in_t px;
    px.sine_x   = 8'(sx);
    px.sine_y   = 8'(sy);
    px.sine_z   = 8'(sz);
    px.cosine_x = 8'(cx);
    px.cosine_y = 8'(cy);
    px.cosine_z = 8'(cz);
    return px;
  endfunction

  // one trig sample, pulled toward the rails and zero
  function automatic int draw_trig();
    case ($urandom_range(0, 15))
      0:       return -128;
      1:       return 127;
      2:       return 0;
      default: return $urandom_range(0, 255) - 128;
    endcase
  endfunction

  // half the pixels look like a real frame: sine and cosine of one angle per axis
  function automatic pixel_in_t draw_pixel();
    real ax, ay, az;
    if ($urandom_range(0, 1) == 0) begin
      ax = $urandom_range(0, 6283) / 1000.0;
      ay = $urandom_range(0, 6283) / 1000.0;
      az = $urandom_range(0, 6283) / 1000.0;
      return make_pixel($rtoi(127.0 * $sin(ax)), $rtoi(127.0 * $sin(ay)),
                        $rtoi(127.0 * $sin(az)), $rtoi(127.0 * $cos(ax)),
                        $rtoi(127.0 * $cos(ay)), $rtoi(127.0 * $cos(az)));
    end
    return make_pixel(draw_trig(), draw_trig(), draw_trig(),
                      draw_trig(), draw_trig(), draw_trig());
  endfunction

  // the first six settings are fixed and mostly hit the register extremes, the rest are random
  function automatic shade_setting_t pick_setting(int phase);
    shade_setting_t s;
    case (phase)
      1: s = '{morph: 8'd0,   sharp: 6'd0,  glow: 8'd0,   drive: 8'd255, hue: 8'd0};
      2: s = '{morph: 8'd127, sharp: 6'd63, glow: 8'd255, drive: 8'd0,   hue: 8'd255};
      3: s = '{morph: 8'd255, sharp: 6'd37, glow: 8'd255, drive: 8'd128, hue: 8'd1};
      4: s = '{morph: 8'd128, sharp: 6'd6,  glow: 8'd128, drive: 8'd255, hue: 8'd200};
      5: s = '{morph: 8'd255, sharp: 6'd63, glow: 8'd0,   drive: 8'd255, hue: 8'd255};
      6: s = '{morph: 8'd64,  sharp: 6'd23, glow: 8'd64,  drive: 8'd1,   hue: 8'd128};
      default: begin
        s.morph = 8'($urandom);
        // sharpness mostly in its useful band, sometimes anywhere in the field
        s.sharp = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(6, 37));
        s.glow  = 8'($urandom);
        s.drive = 8'($urandom);
        s.hue   = 8'($urandom);
      end
    endcase
    return s;
  endfunction

  // holds valid and payload until the word is taken; valid stays up between back to back words
  task automatic send_pixel(input pixel_in_t px, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk_i); while (!in_ready);
    pixels_sent++;
  endtask

  // the count from the scoreboard is registered, so step past the last accept before polling it
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // write enable stays high across a burst of writes, the caller drops it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input shade_setting_t s, input bit poke_reserved);
    write_reg(CfgMorph, s.morph);
    // bits above the sharpness field carry noise the block has to drop
    write_reg(CfgSharp, {2'($urandom), s.sharp});
    write_reg(CfgGlow, s.glow);
    write_reg(CfgDrive, s.drive);
    write_reg(CfgHue, s.hue);
    // writes to indexes past the last register must change nothing
    if (poke_reserved) begin
      for (int idx = int'(CfgHue) + 1; idx < (1 << CfgIdxW); idx++) begin
        write_reg(CfgIdxW'(idx), 8'($urandom));
      end
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // field rails, sign flips and each surface term pushed on its own
  task automatic send_directed();
    send_pixel(make_pixel(-128, -128, -128, -128, -128, -128), 0);
    send_pixel(make_pixel(127, 127, 127, 127, 127, 127), 0);
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0), 0);
    send_pixel(make_pixel(127, 127, 127, -128, -128, -128), 0);
    send_pixel(make_pixel(-128, -128, -128, 127, 127, 127), 0);
    send_pixel(make_pixel(-128, 127, -128, 127, -128, 127), 0);
    send_pixel(make_pixel(1, -1, 1, -1, 1, -1), 0);
    send_pixel(make_pixel(-1, -1, -1, -1, -1, -1), 0);
    send_pixel(make_pixel(127, -128, 0, 0, 127, -128), 0);
    send_pixel(make_pixel(0, 0, 0, 127, 127, 127), 0);
    send_pixel(make_pixel(0, 0, 0, -128, -128, -128), 0);
    send_pixel(make_pixel(127, 0, 0, 0, -128, 0), 0);
  endtask

  // output side: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int gap;
    int quiet_left;
    bit quiet;
    quiet_left = 0;
    quiet      = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_asks != hold_offs_done) begin
        // long stall so the pipe fills and the input side backs up
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_offs_done++;
      end else begin
        if (quiet_left == 0) begin
          quiet      = ($urandom_range(0, 2) == 0);
          quiet_left = $urandom_range(50, 200);
        end
        quiet_left--;
        gap = quiet ? 0 : draw_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // count shaded words for the summary
  always @(posedge clk_i) begin
    if (out_valid && out_ready) words_seen++;
  end

  // ends a hung run: no word on any port for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus: reset, then phases of pixels, each under its own register setting
  initial begin
    bit quiet_sender;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      // phase 0 runs on the reset values of the registers
      if (phase > 0) begin
        apply_setting(pick_setting(phase), phase == 2 || phase > 6);
      end
      // the sender runs without gaps on every third phase
      quiet_sender = (phase % 3 == 2);
      if (phase == 5) hold_off_asks++;
      if (phase == 0 || phase == 3) send_directed();
      for (int n = 0; n < PhaseItems; n++) begin
        send_pixel(draw_pixel(), quiet_sender ? 0 : draw_gap());
      end
      // every word back before the registers move
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d pixels shaded under %0d register settings, %0d words checked",
             pixels_sent, settings_run + 1, words_seen);
    $display("covered morph, sharpness and glow rails, reserved index writes, a long output stall");
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
